// ===== rtl/core/twma_pkg.sv =====
// ----------------------------------------------------------------------------
// Time-window motion accumulator package
// Shared widths, reset constants and the cell control type.
// ----------------------------------------------------------------------------
package twma_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned IN_DELTA_W  = 16;
  localparam int unsigned SUM_W       = 22;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned WIN_W       = 16;

  localparam logic [WIN_W-1:0] WIN_RESET = 16'd10;

  // Item kinds carried on the cmd field.
  localparam logic CMD_FRAME  = 1'b0;
  localparam logic CMD_MOTION = 1'b1;

  // Per-cycle command from the sequencer to every cell of the chain.
  typedef struct packed {
    logic shift;   // every cell takes its upper neighbour's entry
    logic append;  // the cell at the write position takes the new entry
  } cell_ctrl_t;

endpackage

// ===== rtl/core/twma_if.sv =====
// ----------------------------------------------------------------------------
// Time-window motion accumulator channels
// Valid/ready channels for motion items, results and the window register.
// ----------------------------------------------------------------------------
interface twma_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   cmd;
  logic        [twma_pkg::TIME_W-1:0]     event_time;
  logic signed [twma_pkg::IN_DELTA_W-1:0] delta_x;
  logic signed [twma_pkg::IN_DELTA_W-1:0] delta_y;
  logic                                   has_focus;

  modport source (output valid, cmd, event_time, delta_x, delta_y, has_focus,
                  input ready);
  modport sink   (input valid, cmd, event_time, delta_x, delta_y, has_focus,
                  output ready);
endinterface

interface twma_out_if;
  logic                                    valid;
  logic                                    ready;
  logic        [twma_pkg::COUNT_OUT_W-1:0] entry_count;
  logic signed [twma_pkg::SUM_W-1:0]       sum_x;
  logic signed [twma_pkg::SUM_W-1:0]       sum_y;

  modport source (output valid, entry_count, sum_x, sum_y, input ready);
  modport sink   (input valid, entry_count, sum_x, sum_y, output ready);
endinterface

interface twma_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [twma_pkg::WIN_W-1:0]      window_ticks;

  modport source (output valid, window_ticks, input ready);
  modport sink   (input valid, window_ticks, output ready);
endinterface

// ===== rtl/core/twma_cell.sv =====
// ----------------------------------------------------------------------------
// Time-window motion accumulator cell
// Holds one timestamped delta pair of the age-ordered chain.
// ----------------------------------------------------------------------------
module twma_cell #(
  parameter int unsigned DELTA_BITS = 16,
  parameter int unsigned POS_W      = 6,
  parameter int unsigned IDX        = 0
) (
  input  logic                                clk_i,
  input  twma_pkg::cell_ctrl_t                ctrl_i,
  input  logic            [POS_W-1:0]         wr_pos_i,
  input  logic            [twma_pkg::TIME_W-1:0] new_stamp_i,
  input  logic signed     [DELTA_BITS-1:0]    new_x_i,
  input  logic signed     [DELTA_BITS-1:0]    new_y_i,
  input  logic            [twma_pkg::TIME_W-1:0] nb_stamp_i,
  input  logic signed     [DELTA_BITS-1:0]    nb_x_i,
  input  logic signed     [DELTA_BITS-1:0]    nb_y_i,
  output logic            [twma_pkg::TIME_W-1:0] stamp_o,
  output logic signed     [DELTA_BITS-1:0]    x_o,
  output logic signed     [DELTA_BITS-1:0]    y_o
);
  import twma_pkg::*;

  logic                         wr_sel;
  logic [TIME_W-1:0]            stamp_q, stamp_d;
  logic signed [DELTA_BITS-1:0] x_q, x_d, y_q, y_d;

  assign wr_sel = ctrl_i.append && (wr_pos_i == POS_W'(IDX));

  // A write wins over a shift: on a full-ring append the top cell both
  // shifts and receives the new entry.
  always_comb begin
    stamp_d = stamp_q;
    x_d     = x_q;
    y_d     = y_q;
    if (wr_sel) begin
      stamp_d = new_stamp_i;
      x_d     = new_x_i;
      y_d     = new_y_i;
    end else if (ctrl_i.shift) begin
      stamp_d = nb_stamp_i;
      x_d     = nb_x_i;
      y_d     = nb_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    x_q     <= x_d;
    y_q     <= y_d;
  end

  assign stamp_o = stamp_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

// ===== rtl/core/twma_ctrl.sv =====
// ----------------------------------------------------------------------------
// Time-window motion accumulator sequencer
// Handshakes, entry count, running sums and the purge loop over the chain.
// ----------------------------------------------------------------------------
module twma_ctrl #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DELTA_BITS = 16,
  parameter int unsigned POS_W      = $clog2(DEPTH)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  twma_in_if.sink                            in_i,
  twma_out_if.source                         out_o,
  twma_cfg_if.sink                           cfg_i,
  input  logic        [twma_pkg::TIME_W-1:0] head_stamp_i,
  input  logic signed [DELTA_BITS-1:0]       head_x_i,
  input  logic signed [DELTA_BITS-1:0]       head_y_i,
  output twma_pkg::cell_ctrl_t               ctrl_o,
  output logic        [POS_W-1:0]            wr_pos_o,
  output logic        [twma_pkg::TIME_W-1:0] new_stamp_o,
  output logic signed [DELTA_BITS-1:0]       new_x_o,
  output logic signed [DELTA_BITS-1:0]       new_y_o
);
  import twma_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MOTION = 4'b0010,
    ST_PURGE  = 4'b0100,
    ST_REPORT = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [WIN_W-1:0]             win_q;
  logic [TIME_W-1:0]            time_q, time_d;
  logic signed [DELTA_BITS-1:0] dx_q, dx_d, dy_q, dy_d;
  logic                         focus_q, focus_d;
  logic [CNT_W-1:0]             fill_q, fill_d;
  logic [SUM_W-1:0]             sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic                         out_valid_q, out_valid_d;
  logic [COUNT_OUT_W-1:0]       out_cnt_q, out_cnt_d;
  logic [SUM_W-1:0]             out_x_q, out_x_d, out_y_q, out_y_d;

  logic                         in_fire, full, out_free;
  cell_ctrl_t                   ctrl;
  logic signed [31:0]           in_x32, in_y32, head_x32, head_y32, new_x32, new_y32;
  logic [31:0]                  fill32;
  logic [SUM_W-1:0]             sub_x, sub_y, add_x, add_y;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign full        = (fill_q == CNT_W'(DEPTH));
  assign out_free    = !out_valid_q || out_o.ready;

  // Inputs are narrowed to DELTA_BITS (or sign-extended when wider).
  assign in_x32   = 32'(in_i.delta_x);
  assign in_y32   = 32'(in_i.delta_y);
  assign head_x32 = 32'(head_x_i);
  assign head_y32 = 32'(head_y_i);
  assign new_x32  = 32'(dx_q);
  assign new_y32  = 32'(dy_q);
  assign fill32   = 32'(fill_q);

  assign sub_x = ctrl.shift  ? head_x32[SUM_W-1:0] : '0;
  assign sub_y = ctrl.shift  ? head_y32[SUM_W-1:0] : '0;
  assign add_x = ctrl.append ? new_x32[SUM_W-1:0]  : '0;
  assign add_y = ctrl.append ? new_y32[SUM_W-1:0]  : '0;

  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    focus_d     = focus_q;
    fill_d      = fill_q;
    ctrl        = '0;
    wr_pos_o    = fill_q[POS_W-1:0];
    out_valid_d = out_valid_q && !out_o.ready;
    out_cnt_d   = out_cnt_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          dx_d    = in_x32[DELTA_BITS-1:0];
          dy_d    = in_y32[DELTA_BITS-1:0];
          focus_d = in_i.has_focus;
          if (in_i.cmd == CMD_FRAME) begin
            // Hold the purge cutoff rather than the frame time.
            time_d  = in_i.event_time - TIME_W'(win_q);
            state_d = ST_PURGE;
          end else begin
            time_d  = in_i.event_time;
            state_d = ST_MOTION;
          end
        end
      end
      ST_MOTION: begin
        if (focus_q) begin
          ctrl.append = 1'b1;
          if (full) begin
            ctrl.shift = 1'b1;
            wr_pos_o   = POS_W'(DEPTH - 1);
          end else begin
            fill_d = fill_q + CNT_W'(1);
          end
        end
        state_d = ST_REPORT;
      end
      ST_PURGE: begin
        if ((fill_q != '0) && (head_stamp_i < time_q)) begin
          ctrl.shift = 1'b1;
          fill_d     = fill_q - CNT_W'(1);
        end else begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cnt_d   = fill32[COUNT_OUT_W-1:0];
          out_x_d     = sum_x_q;
          out_y_d     = sum_y_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    sum_x_d = sum_x_q - sub_x + add_x;
    sum_y_d = sum_y_q - sub_y + add_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WIN_RESET;
      fill_q      <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        win_q <= cfg_i.window_ticks;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    time_q    <= time_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    focus_q   <= focus_d;
    out_cnt_q <= out_cnt_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
  end

  assign ctrl_o            = ctrl;
  assign new_stamp_o       = time_q;
  assign new_x_o           = dx_q;
  assign new_y_o           = dy_q;
  assign out_o.valid       = out_valid_q;
  assign out_o.entry_count = out_cnt_q;
  assign out_o.sum_x       = out_x_q;
  assign out_o.sum_y       = out_y_q;

  // The count never exceeds the number of cells.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DEPTH))
    else $error("entry count above ring depth");

  // An accepted item always starts either an append or a purge.
  a_accept_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_MOTION || state_q == ST_PURGE))
    else $error("accepted item did not start processing");

  // The chain is only touched while an item is being processed.
  a_fill_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_REPORT) |=> $stable(fill_q))
    else $error("entry count changed outside processing");

  // An empty ring ends a purge at once.
  a_purge_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PURGE && fill_q == '0) |=> (state_q == ST_REPORT))
    else $error("purge continued on an empty ring");

  // A result is loaded only when the output slot is free.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_x_q)))
    else $error("pending result overwritten");

endmodule

// ===== rtl/core/time_window_motion_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// Time-window motion accumulator
// Age-ordered chain of motion deltas with running x/y sums and a time purge.
// ----------------------------------------------------------------------------
// Usage. Items arrive on in_i: a motion item (cmd = 1) with focus is appended
// behind the newest entry, dropping the oldest first when all RING_DEPTH cells
// are occupied; a motion item without focus leaves the state alone. A frame
// item (cmd = 0) carries the current time and removes, oldest first, every
// entry stamped below the current time minus window_ticks (modulo 2^32).
// Each transaction on in_i yields exactly one transaction on out_o carrying
// the entry count and both sums after the item. window_ticks is written over
// cfg_i, which is always ready, and must only change while the block is idle.
// A motion item passes through capture, update and report before the next
// acceptance; a frame item passes through capture, the purge loop and report,
// and the purge loop pops the head of the chain once per cycle. The result
// register parts the two sides, so a new item is taken while a result is
// still waiting; if the receiver stalls long enough the sequencer holds in
// its report step and in_i stays not ready.
// After reset the ring is empty, both sums are zero and window_ticks is 10;
// the cell contents are not cleared, as only occupied cells are ever read.
// ----------------------------------------------------------------------------
module time_window_motion_accumulator_core #(
  parameter int unsigned RING_DEPTH = 64,
  parameter int unsigned DELTA_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  twma_in_if.sink    in_i,
  twma_out_if.source out_o,
  twma_cfg_if.sink   cfg_i
);
  import twma_pkg::*;

  localparam int unsigned POS_W = $clog2(RING_DEPTH);

  // Cell 0 always holds the oldest entry; younger entries sit above it.
  logic        [TIME_W-1:0]     stamp_w [RING_DEPTH];
  logic signed [DELTA_BITS-1:0] x_w     [RING_DEPTH];
  logic signed [DELTA_BITS-1:0] y_w     [RING_DEPTH];

  cell_ctrl_t                   cell_ctrl;
  logic        [POS_W-1:0]      wr_pos;
  logic        [TIME_W-1:0]     new_stamp;
  logic signed [DELTA_BITS-1:0] new_x, new_y;

  twma_ctrl #(
    .DEPTH      (RING_DEPTH),
    .DELTA_BITS (DELTA_BITS),
    .POS_W      (POS_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .cfg_i        (cfg_i),
    .head_stamp_i (stamp_w[0]),
    .head_x_i     (x_w[0]),
    .head_y_i     (y_w[0]),
    .ctrl_o       (cell_ctrl),
    .wr_pos_o     (wr_pos),
    .new_stamp_o  (new_stamp),
    .new_x_o      (new_x),
    .new_y_o      (new_y)
  );

  // Popping the head moves every entry one cell down the chain. The top
  // cell has no upper neighbour and simply keeps its own contents, which
  // are then beyond the fill count and never read.
  for (genvar k = 0; k < RING_DEPTH; k++) begin : g_cell
    localparam int unsigned NB = (k == RING_DEPTH - 1) ? k : k + 1;

    twma_cell #(
      .DELTA_BITS (DELTA_BITS),
      .POS_W      (POS_W),
      .IDX        (k)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .wr_pos_i    (wr_pos),
      .new_stamp_i (new_stamp),
      .new_x_i     (new_x),
      .new_y_i     (new_y),
      .nb_stamp_i  (stamp_w[NB]),
      .nb_x_i      (x_w[NB]),
      .nb_y_i      (y_w[NB]),
      .stamp_o     (stamp_w[k]),
      .x_o         (x_w[k]),
      .y_o         (y_w[k])
    );
  end

endmodule
